// ----- rtl/lrw_pkg.sv -----
`default_nettype none

package lrw_pkg;

    // Field widths
    localparam int unsigned FUNC_W  = 4;
    localparam int unsigned TICKS_W = 32;
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 40;

    // Register indexes on the configuration port
    localparam logic CFG_PERIOD   = 1'b0;
    localparam logic CFG_ECHO_TMO = 1'b1;

    // Register reset values
    localparam logic [TICKS_W-1:0] PERIOD_RESET   = 32'd1000;
    localparam logic [TICKS_W-1:0] ECHO_TMO_RESET = 32'd500;

    // Event codes; codes 10 to 15 are ignored
    typedef enum logic [FUNC_W-1:0] {
        EV_TICK     = 4'd0,
        EV_BEACON   = 4'd1,
        EV_ANOMALY  = 4'd2,
        EV_MESSAGE  = 4'd3,
        EV_REPLY    = 4'd4,
        EV_BACKLOG  = 4'd5,
        EV_CONNECT  = 4'd6,
        EV_SENDTMO  = 4'd7,
        EV_CANCEL   = 4'd8,
        EV_SHUTDOWN = 4'd9
    } lrw_event_t;

    // Watchdog state carried from one item to the next
    typedef struct packed {
        logic               reply_awaited;
        logic               beacon_suspect;
        logic               probe_late;
        logic               closing;
        logic               armed;
        logic [TICKS_W-1:0] countdown;
    } lrw_state_t;

    // Input item
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              receiver_busy;
        logic              echo_queued;
    } lrw_item_t;

    // Result item
    typedef struct packed {
        logic               echo_request;
        logic               disconnect_circuit;
        logic               circuit_responsive;
        logic               timer_running;
        logic [TICKS_W-1:0] remaining_ticks;
        logic               probe_pending;
    } lrw_result_t;

endpackage

`default_nettype wire

// ----- rtl/lrw_event.sv -----
`default_nettype none

module lrw_event
    import lrw_pkg::*;
(
    input  wire lrw_state_t         state_cur,
    input  wire lrw_item_t          item,
    input  wire logic [TICKS_W-1:0] period_ticks,
    input  wire logic [TICKS_W-1:0] echo_timeout_ticks,
    output lrw_state_t              state_upd,
    output lrw_result_t             result
);

    logic echo;
    logic disc;
    logic resp;
    logic expiring;

    assign expiring = state_cur.armed && (state_cur.countdown[TICKS_W-1:1] == '0);

    // Apply one event to the watchdog state.
    always_comb begin
        state_upd = state_cur;
        echo = 1'b0;
        disc = 1'b0;
        resp = 1'b0;
        unique case (item.func)
            EV_TICK: begin
                if (expiring) begin
                    // The timer stops first; each branch may restart it.
                    state_upd.armed = 1'b0;
                    state_upd.countdown = '0;
                    if (state_cur.closing) begin
                        state_upd.armed = 1'b0;
                    end else if (state_cur.reply_awaited) begin
                        if (item.receiver_busy) begin
                            state_upd.armed = 1'b1;
                            state_upd.countdown = echo_timeout_ticks;
                        end else begin
                            disc = 1'b1;
                            state_upd.probe_late = 1'b1;
                        end
                    end else if (item.receiver_busy) begin
                        state_upd.armed = 1'b1;
                        state_upd.countdown = period_ticks;
                    end else begin
                        state_upd.probe_late = 1'b0;
                        echo = 1'b1;
                        state_upd.reply_awaited = item.echo_queued;
                        state_upd.armed = 1'b1;
                        state_upd.countdown = echo_timeout_ticks;
                    end
                end else if (state_cur.armed) begin
                    state_upd.countdown = state_cur.countdown - 32'd1;
                end
            end
            EV_BEACON: begin
                if (!(state_cur.closing || state_cur.beacon_suspect
                      || state_cur.reply_awaited)) begin
                    state_upd.armed = 1'b1;
                    state_upd.countdown = period_ticks;
                end
            end
            EV_ANOMALY: begin
                state_upd.beacon_suspect = 1'b1;
            end
            EV_MESSAGE: begin
                if (!(state_cur.closing || state_cur.reply_awaited)) begin
                    state_upd.beacon_suspect = 1'b0;
                    state_upd.armed = 1'b1;
                    state_upd.countdown = period_ticks;
                end
            end
            EV_REPLY: begin
                if (state_cur.reply_awaited && !state_cur.closing) begin
                    if (state_cur.probe_late) begin
                        state_upd.probe_late = 1'b0;
                        echo = 1'b1;
                        state_upd.reply_awaited = item.echo_queued;
                        state_upd.armed = 1'b1;
                        state_upd.countdown = echo_timeout_ticks;
                    end else begin
                        state_upd.reply_awaited = 1'b0;
                        resp = 1'b1;
                        state_upd.armed = 1'b1;
                        state_upd.countdown = period_ticks;
                    end
                end
            end
            EV_BACKLOG: begin
                if (state_cur.reply_awaited && !state_cur.closing) begin
                    state_upd.armed = 1'b1;
                    state_upd.countdown = echo_timeout_ticks;
                end
            end
            EV_CONNECT: begin
                if (!state_cur.closing) begin
                    state_upd.armed = 1'b1;
                    state_upd.countdown = period_ticks;
                end
            end
            EV_SENDTMO: begin
                if (!(state_cur.reply_awaited || state_cur.closing)) begin
                    echo = 1'b1;
                    state_upd.reply_awaited = item.echo_queued;
                    state_upd.armed = 1'b1;
                    state_upd.countdown = echo_timeout_ticks;
                end
            end
            EV_CANCEL: begin
                state_upd.armed = 1'b0;
                state_upd.countdown = '0;
            end
            EV_SHUTDOWN: begin
                state_upd.closing = 1'b1;
                state_upd.armed = 1'b0;
                state_upd.countdown = '0;
            end
            default: begin
                state_upd = state_cur;
            end
        endcase
    end

    // Strobes and status after the event.
    always_comb begin
        result.echo_request       = echo;
        result.disconnect_circuit = disc;
        result.circuit_responsive = resp;
        result.timer_running      = state_upd.armed;
        result.remaining_ticks    = state_upd.armed ? state_upd.countdown : '0;
        result.probe_pending      = state_upd.reply_awaited;
    end

endmodule

`default_nettype wire

// ----- rtl/link_receive_watchdog.sv -----
`default_nettype none

// Channel   Direction  tdata fields (lowest bit up)
// s_        in         func[3:0], receiver_busy[4], echo_queued[5], zero[7:6]
// m_        out        echo_request[0], disconnect_circuit[1],
//                      circuit_responsive[2], timer_running[3],
//                      remaining_ticks[35:4], probe_pending[36], zero[39:37]
// cfg_      in         index 0 period_ticks, index 1 echo_timeout_ticks
//
// One item per cycle sustained while m_ does not stall. An accepted item waits
// in an input register; the event logic updates the state as the item moves
// to the result register, which drives m_, so each item sees the
// state left by the one before. A stall on m_ holds the result register and
// then the input register; s_tready drops only when both are full.
// Reset (aresetn low, synchronous) empties both stages and loads the
// register defaults and the watchdog reset state.

module link_receive_watchdog
    import lrw_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // func, receiver_busy, echo_queued
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // echo_request, disconnect_circuit,
                                                   // circuit_responsive, timer_running,
                                                   // remaining_ticks, probe_pending
    input  wire logic                   cfg_we,
    input  wire logic                   cfg_index,
    input  wire logic [TICKS_W-1:0]     cfg_wdata
);

    logic               in_valid_reg;
    lrw_item_t          in_item_reg;
    logic               out_valid_reg;
    lrw_result_t        out_result_reg;
    lrw_state_t         state_reg;
    lrw_state_t         state_next;
    lrw_result_t        result_next;
    logic [TICKS_W-1:0] period_reg;
    logic [TICKS_W-1:0] echo_tmo_reg;
    logic               advance;
    logic               s_accept;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg   <= PERIOD_RESET;
            echo_tmo_reg <= ECHO_TMO_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PERIOD:   period_reg   <= cfg_wdata;
                CFG_ECHO_TMO: echo_tmo_reg <= cfg_wdata;
                default:      period_reg   <= period_reg;
            endcase
        end
    end

    // Input stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.func          <= s_tdata[FUNC_W-1:0];
            in_item_reg.receiver_busy <= s_tdata[FUNC_W];
            in_item_reg.echo_queued   <= s_tdata[FUNC_W+1];
        end
    end

    // Event logic.
    lrw_event u_event (
        .state_cur          (state_reg),
        .item               (in_item_reg),
        .period_ticks       (period_reg),
        .echo_timeout_ticks (echo_tmo_reg),
        .state_upd          (state_next),
        .result             (result_next)
    );

    // Watchdog state moves on as each item leaves the input stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.reply_awaited  <= 1'b0;
            state_reg.beacon_suspect <= 1'b1;
            state_reg.probe_late     <= 1'b0;
            state_reg.closing        <= 1'b0;
            state_reg.armed          <= 1'b0;
            state_reg.countdown      <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_result_reg.probe_pending,
                       out_result_reg.remaining_ticks,
                       out_result_reg.timer_running,
                       out_result_reg.circuit_responsive,
                       out_result_reg.disconnect_circuit,
                       out_result_reg.echo_request};

`ifndef SYNTHESIS
    // A stopped timer always holds zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !state_reg.armed |-> state_reg.countdown == '0)
        else $error("timer disarmed with a nonzero count");

    // Once shutting down, the timer never runs again.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.closing |-> !state_reg.armed)
        else $error("timer armed while shutting down");

    // A probe and a disconnect never come from the same item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(out_result_reg.echo_request && out_result_reg.disconnect_circuit))
        else $error("echo request and disconnect in one result");

    // Both stages full and stalled means no new item is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while both stages are stalled");
`endif

endmodule

`default_nettype wire
